[sv/autonomous_drive_supervisor_fsm_unit_assert.svh]
// ----------------------------------------------------------------------------
// Supervisor assertion macros
// Concurrent assertion wrappers for the supervisor RTL.
// ----------------------------------------------------------------------------
`ifndef AUTONOMOUS_DRIVE_SUPERVISOR_FSM_UNIT_ASSERT_SVH
`define AUTONOMOUS_DRIVE_SUPERVISOR_FSM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define ADSF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("supervisor same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ADSF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("supervisor next-cycle check failed");

`else

`define ADSF_ASSERT_IMP(label, clk, rst, ante, cons)
`define ADSF_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

[sv/adsf_pkg.sv]
// ----------------------------------------------------------------------------
// Supervisor package
// Codes, field types and stage structures for the drive supervisor.
// ----------------------------------------------------------------------------
package adsf_pkg;

   typedef enum logic [3:0] {
      ST_START    = 4'd0,
      ST_SELECT   = 4'd1,
      ST_WAIT     = 4'd2,
      ST_CHECK    = 4'd3,
      ST_READY    = 4'd4,
      ST_RELEASE  = 4'd5,
      ST_DRIVE    = 4'd6,
      ST_ACTIVATE = 4'd7,
      ST_FINISHED = 4'd8,
      ST_EMERG    = 4'd9
   } state_type;

   typedef enum logic [2:0] {
      AS_OFF    = 3'd0,
      AS_READY  = 3'd1,
      AS_DRIVE  = 3'd2,
      AS_EBRAKE = 3'd3,
      AS_FINISH = 3'd4
   } as_type;

   typedef enum logic [2:0] {
      BC_OTHER    = 3'd0,
      BC_READY    = 3'd1,
      BC_SHUTDOWN = 3'd2,
      BC_DRIVE    = 3'd3,
      BC_BRAKE    = 3'd4
   } brake_code_type;

   typedef enum logic [1:0] {
      SS_OTHER  = 2'd0,
      SS_SELECT = 2'd1,
      SS_ACK    = 2'd2
   } steer_code_type;

   typedef enum logic [2:0] {
      MS_NONE    = 3'd0,
      MS_MANUAL  = 3'd1,
      MS_INSPECT = 3'd2,
      MS_BRAKE   = 3'd3,
      MS_TRACK   = 3'd4
   } mission_type;

   typedef enum logic [1:0] {
      AMI_NONE    = 2'd0,
      AMI_INSPECT = 2'd1,
      AMI_BRAKE   = 2'd2,
      AMI_TRACK   = 2'd3
   } ami_type;

   typedef enum logic [1:0] {
      HB_NONE   = 2'd0,
      HB_MANUAL = 2'd1,
      HB_AUTO   = 2'd2
   } hb_type;

   // One heartbeat tick as held in the input register.
   typedef struct packed {
      logic               res_switch_forward;
      logic               res_go_button;
      logic               res_estop;
      logic [2:0]         brake_ctrl_state;
      logic [1:0]         steer_state;
      logic [2:0]         steer_mission;
      logic signed [15:0] torque_demand;
   } tick_type;

   // Persistent supervisor state.
   typedef struct packed {
      state_type  fsm_state;
      logic [2:0] active_mission;
      logic [1:0] ami_reg;
      logic [1:0] hb_mission_reg;
   } regs_type;

   // One result as held in the result register.
   typedef struct packed {
      logic [3:0]         supervisor_state;
      logic [2:0]         as_status;
      logic [1:0]         ami_status;
      logic [1:0]         heartbeat_mission;
      logic signed [15:0] torque_request;
      logic               launch_pulse;
      logic [2:0]         launch_mission_code;
   } result_type;

endpackage

[sv/adsf_channels.sv]
// ----------------------------------------------------------------------------
// Supervisor channels
// Valid/ready channel interfaces for heartbeat ticks and supervisor results.
// ----------------------------------------------------------------------------
interface adsf_req_if;
   logic               valid;
   logic               ready;
   logic               res_switch_forward;
   logic               res_go_button;
   logic               res_estop;
   logic [2:0]         brake_ctrl_state;
   logic [1:0]         steer_state;
   logic [2:0]         steer_mission;
   logic signed [15:0] torque_demand;

   modport source (
      output valid, res_switch_forward, res_go_button, res_estop,
             brake_ctrl_state, steer_state, steer_mission, torque_demand,
      input  ready
   );

   modport sink (
      input  valid, res_switch_forward, res_go_button, res_estop,
             brake_ctrl_state, steer_state, steer_mission, torque_demand,
      output ready
   );
endinterface

interface adsf_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         supervisor_state;
   logic [2:0]         as_status;
   logic [1:0]         ami_status;
   logic [1:0]         heartbeat_mission;
   logic signed [15:0] torque_request;
   logic               launch_pulse;
   logic [2:0]         launch_mission_code;

   modport source (
      output valid, supervisor_state, as_status, ami_status, heartbeat_mission,
             torque_request, launch_pulse, launch_mission_code,
      input  ready
   );

   modport sink (
      input  valid, supervisor_state, as_status, ami_status, heartbeat_mission,
             torque_request, launch_pulse, launch_mission_code,
      output ready
   );
endinterface

[sv/adsf_step.sv]
// ----------------------------------------------------------------------------
// Supervisor step logic
// Visits the supervisor states in order for one tick, letting transitions
// chain, then applies the e-stop override.
// ----------------------------------------------------------------------------
module adsf_step (
   input  adsf_pkg::tick_type   tick,
   input  adsf_pkg::regs_type   regs,
   output adsf_pkg::regs_type   regs_next,
   output adsf_pkg::result_type result
);

   always_comb begin
      adsf_pkg::state_type st;
      logic [2:0]          mission;
      logic [1:0]          ami;
      logic [1:0]          hb;
      logic [2:0]          as_code;
      logic signed [15:0]  torque;
      logic                pulse;
      logic [2:0]          code;

      st      = regs.fsm_state;
      mission = regs.active_mission;
      ami     = regs.ami_reg;
      hb      = regs.hb_mission_reg;
      as_code = adsf_pkg::AS_OFF;
      torque  = '0;
      pulse   = 1'b0;
      code    = adsf_pkg::MS_NONE;

      if (st == adsf_pkg::ST_START) begin
         as_code = adsf_pkg::AS_OFF;
         mission = adsf_pkg::MS_NONE;
         hb      = adsf_pkg::HB_NONE;
         if (!tick.res_switch_forward) begin
            st = adsf_pkg::ST_SELECT;
         end
      end
      if (st == adsf_pkg::ST_SELECT) begin
         as_code = adsf_pkg::AS_OFF;
         if (tick.steer_state == adsf_pkg::SS_SELECT ||
             tick.steer_state == adsf_pkg::SS_ACK) begin
            st = adsf_pkg::ST_WAIT;
         end
      end
      if (st == adsf_pkg::ST_WAIT) begin
         as_code = adsf_pkg::AS_OFF;
         if (tick.steer_state == adsf_pkg::SS_ACK) begin
            mission = tick.steer_mission;
            pulse   = 1'b1;
            code    = tick.steer_mission;
         end
         if (mission != adsf_pkg::MS_NONE) begin
            case (mission)
               adsf_pkg::MS_INSPECT: ami = adsf_pkg::AMI_INSPECT;
               adsf_pkg::MS_BRAKE:   ami = adsf_pkg::AMI_BRAKE;
               adsf_pkg::MS_TRACK:   ami = adsf_pkg::AMI_TRACK;
               default:              ami = adsf_pkg::AMI_NONE;
            endcase
            st = adsf_pkg::ST_CHECK;
            hb = (mission == adsf_pkg::MS_MANUAL) ? adsf_pkg::HB_MANUAL : adsf_pkg::HB_AUTO;
         end
      end
      if (st == adsf_pkg::ST_CHECK) begin
         as_code = adsf_pkg::AS_OFF;
         if (tick.brake_ctrl_state == adsf_pkg::BC_READY && tick.res_switch_forward) begin
            st = adsf_pkg::ST_READY;
         end
      end
      if (st == adsf_pkg::ST_READY) begin
         as_code = adsf_pkg::AS_READY;
         if (tick.res_go_button) begin
            st = adsf_pkg::ST_RELEASE;
         end
         if (tick.brake_ctrl_state == adsf_pkg::BC_SHUTDOWN) begin
            st = adsf_pkg::ST_EMERG;
         end
      end
      if (st == adsf_pkg::ST_RELEASE) begin
         as_code = adsf_pkg::AS_DRIVE;
         if (tick.brake_ctrl_state == adsf_pkg::BC_DRIVE) begin
            st = adsf_pkg::ST_DRIVE;
         end
         if (tick.brake_ctrl_state == adsf_pkg::BC_SHUTDOWN) begin
            st = adsf_pkg::ST_EMERG;
         end
      end
      if (st == adsf_pkg::ST_DRIVE) begin
         as_code = adsf_pkg::AS_DRIVE;
         torque  = tick.torque_demand;
         if (tick.brake_ctrl_state == adsf_pkg::BC_SHUTDOWN) begin
            st = adsf_pkg::ST_EMERG;
         end
      end
      if (st == adsf_pkg::ST_ACTIVATE) begin
         as_code = adsf_pkg::AS_FINISH;
         if (tick.brake_ctrl_state == adsf_pkg::BC_BRAKE) begin
            st = adsf_pkg::ST_FINISHED;
         end
      end
      if (st == adsf_pkg::ST_FINISHED) begin
         as_code = adsf_pkg::AS_FINISH;
         torque  = '0;
         if (!tick.res_switch_forward) begin
            st = adsf_pkg::ST_START;
         end
      end
      if (st == adsf_pkg::ST_EMERG) begin
         as_code = adsf_pkg::AS_EBRAKE;
         torque  = '0;
         if (!tick.res_estop && !tick.res_switch_forward) begin
            st = adsf_pkg::ST_START;
         end
      end
      // The e-stop wins over every transition but leaves the AS status alone.
      if (tick.res_estop) begin
         torque = '0;
         st     = adsf_pkg::ST_EMERG;
      end

      regs_next.fsm_state      = st;
      regs_next.active_mission = mission;
      regs_next.ami_reg        = ami;
      regs_next.hb_mission_reg = hb;

      result.supervisor_state    = st;
      result.as_status           = as_code;
      result.ami_status          = ami;
      result.heartbeat_mission   = hb;
      result.torque_request      = torque;
      result.launch_pulse        = pulse;
      result.launch_mission_code = code;
   end

endmodule

[sv/autonomous_drive_supervisor_fsm_unit.sv]
// ----------------------------------------------------------------------------
// Autonomous drive supervisor
// Heartbeat-driven supervisor state machine with input and result registers.
//
//   Channel  Direction  Transaction
//   req_ch   in         one heartbeat tick: remote, brake, steering, torque
//   rsp_ch   out        one supervisor result per tick
//
// A tick can be accepted every cycle unless a stalled result holds both registers.
// It waits in the input register, then the step logic writes the result register,
// which offers the result on rsp_ch until it is taken.
// Reset puts the machine in the start state with no mission and empties
// both registers.
// A stalled result holds the result register; the input register still takes
// a tick and ready falls only when both registers are full.
// ----------------------------------------------------------------------------
`include "autonomous_drive_supervisor_fsm_unit_assert.svh"

module autonomous_drive_supervisor_fsm_unit (
   input logic            clock,
   input logic            reset,
   adsf_req_if.sink       req_ch,
   adsf_rsp_if.source     rsp_ch
);

   logic                 in_valid_ff;
   adsf_pkg::tick_type   in_data_ff;
   logic                 out_valid_ff;
   adsf_pkg::result_type out_data_ff;
   adsf_pkg::regs_type   regs_ff;
   adsf_pkg::regs_type   regs_in;
   adsf_pkg::result_type result_in;
   logic                 out_free;
   logic                 advance;
   logic                 req_take;

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign advance  = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_take = req_ch.valid && req_ch.ready;

   adsf_step u_step (
      .tick      (in_data_ff),
      .regs      (regs_ff),
      .regs_next (regs_in),
      .result    (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
         regs_ff.fsm_state      <= adsf_pkg::ST_START;
         regs_ff.active_mission <= adsf_pkg::MS_NONE;
         regs_ff.ami_reg        <= adsf_pkg::AMI_NONE;
         regs_ff.hb_mission_reg <= adsf_pkg::HB_NONE;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            regs_ff <= regs_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff.res_switch_forward <= req_ch.res_switch_forward;
         in_data_ff.res_go_button      <= req_ch.res_go_button;
         in_data_ff.res_estop          <= req_ch.res_estop;
         in_data_ff.brake_ctrl_state   <= req_ch.brake_ctrl_state;
         in_data_ff.steer_state        <= req_ch.steer_state;
         in_data_ff.steer_mission      <= req_ch.steer_mission;
         in_data_ff.torque_demand      <= req_ch.torque_demand;
      end
      if (advance) begin
         out_data_ff <= result_in;
      end
   end

   assign rsp_ch.valid               = out_valid_ff;
   assign rsp_ch.supervisor_state    = out_data_ff.supervisor_state;
   assign rsp_ch.as_status           = out_data_ff.as_status;
   assign rsp_ch.ami_status          = out_data_ff.ami_status;
   assign rsp_ch.heartbeat_mission   = out_data_ff.heartbeat_mission;
   assign rsp_ch.torque_request      = out_data_ff.torque_request;
   assign rsp_ch.launch_pulse        = out_data_ff.launch_pulse;
   assign rsp_ch.launch_mission_code = out_data_ff.launch_mission_code;

   // Torque only leaves the block from the drive state.
   `ADSF_ASSERT_IMP(a_torque_only_drive, clock, reset,
      out_valid_ff && out_data_ff.torque_request != 16'sd0,
      out_data_ff.supervisor_state == adsf_pkg::ST_DRIVE)
   // A mission code is reported only with the launch pulse.
   `ADSF_ASSERT_IMP(a_code_with_pulse, clock, reset,
      out_valid_ff && !out_data_ff.launch_pulse,
      out_data_ff.launch_mission_code == adsf_pkg::MS_NONE)
   // An e-stop tick leaves the machine in the emergency state.
   `ADSF_ASSERT_NXT(a_estop_emerg, clock, reset,
      advance && in_data_ff.res_estop,
      regs_ff.fsm_state == adsf_pkg::ST_EMERG)
   // Driving status comes only from release, drive, or an e-stop taken there.
   `ADSF_ASSERT_IMP(a_drive_status, clock, reset,
      out_valid_ff && out_data_ff.as_status == adsf_pkg::AS_DRIVE,
      out_data_ff.supervisor_state == adsf_pkg::ST_RELEASE ||
      out_data_ff.supervisor_state == adsf_pkg::ST_DRIVE ||
      out_data_ff.supervisor_state == adsf_pkg::ST_EMERG)

endmodule

[tb/sv/adsf_supervisor_checker_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Supervisor result checker
// Tracks the supervisor state machine tick by tick, keeps the results still
// owed by the block in order, and compares each delivered result with them.
// ----------------------------------------------------------------------------
package adsf_supervisor_checker_pkg;

   import adsf_pkg::*;

   class supervisor_checker;

      logic [3:0]  fsm_state;
      logic [2:0]  active_mission;
      logic [1:0]  ami_reg;
      logic [1:0]  hb_mission;
      result_type  owed_results[$];
      int          mismatches;

      function new();
         fsm_state      = ST_START;
         active_mission = MS_NONE;
         ami_reg        = AMI_NONE;
         hb_mission     = HB_NONE;
         mismatches     = 0;
      endfunction

      function logic [3:0] state_now();
         return fsm_state;
      endfunction

      function int pending();
         return owed_results.size();
      endfunction

      // Walks the state blocks in their fixed order, so one tick may chain
      // several transitions before the e-stop override at the end.
      function result_type advance_supervisor(tick_type t);
         logic [3:0]         st;
         logic [2:0]         as_code;
         logic signed [15:0] torque;
         result_type         r;
         st      = fsm_state;
         as_code = AS_OFF;
         torque  = '0;
         r       = '0;
         if (st == ST_START) begin
            as_code        = AS_OFF;
            active_mission = MS_NONE;
            hb_mission     = HB_NONE;
            if (!t.res_switch_forward) st = ST_SELECT;
         end
         if (st == ST_SELECT) begin
            as_code = AS_OFF;
            if (t.steer_state == SS_SELECT || t.steer_state == SS_ACK) st = ST_WAIT;
         end
         if (st == ST_WAIT) begin
            as_code = AS_OFF;
            if (t.steer_state == SS_ACK) begin
               active_mission        = t.steer_mission;
               r.launch_pulse        = 1'b1;
               r.launch_mission_code = t.steer_mission;
            end
            if (active_mission != MS_NONE) begin
               case (active_mission)
                  MS_INSPECT: ami_reg = AMI_INSPECT;
                  MS_BRAKE:   ami_reg = AMI_BRAKE;
                  MS_TRACK:   ami_reg = AMI_TRACK;
                  default:    ami_reg = AMI_NONE;
               endcase
               st         = ST_CHECK;
               hb_mission = (active_mission == MS_MANUAL) ? HB_MANUAL : HB_AUTO;
            end
         end
         if (st == ST_CHECK) begin
            as_code = AS_OFF;
            if (t.brake_ctrl_state == BC_READY && t.res_switch_forward) st = ST_READY;
         end
         if (st == ST_READY) begin
            as_code = AS_READY;
            if (t.res_go_button) st = ST_RELEASE;
            if (t.brake_ctrl_state == BC_SHUTDOWN) st = ST_EMERG;
         end
         if (st == ST_RELEASE) begin
            as_code = AS_DRIVE;
            if (t.brake_ctrl_state == BC_DRIVE) st = ST_DRIVE;
            if (t.brake_ctrl_state == BC_SHUTDOWN) st = ST_EMERG;
         end
         if (st == ST_DRIVE) begin
            as_code = AS_DRIVE;
            torque  = t.torque_demand;
            if (t.brake_ctrl_state == BC_SHUTDOWN) st = ST_EMERG;
         end
         if (st == ST_ACTIVATE) begin
            as_code = AS_FINISH;
            if (t.brake_ctrl_state == BC_BRAKE) st = ST_FINISHED;
         end
         if (st == ST_FINISHED) begin
            as_code = AS_FINISH;
            torque  = '0;
            if (!t.res_switch_forward) st = ST_START;
         end
         if (st == ST_EMERG) begin
            as_code = AS_EBRAKE;
            torque  = '0;
            if (!t.res_estop && !t.res_switch_forward) st = ST_START;
         end
         // The e-stop wins over everything but leaves the status of this tick alone.
         if (t.res_estop) begin
            torque = '0;
            st     = ST_EMERG;
         end
         fsm_state           = st;
         r.supervisor_state  = st;
         r.as_status         = as_code;
         r.ami_status        = ami_reg;
         r.heartbeat_mission = hb_mission;
         r.torque_request    = torque;
         return r;
      endfunction

      function void note_tick(tick_type t);
         owed_results.push_back(advance_supervisor(t));
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (owed_results.size() == 0) begin
            $display("%0t: unexpected result transaction, state %0d, torque %0d",
                     $time, got.supervisor_state, got.torque_request);
            mismatches++;
            return;
         end
         want = owed_results.pop_front();
         compare_field("supervisor_state", want.supervisor_state, got.supervisor_state);
         compare_field("as_status", want.as_status, got.as_status);
         compare_field("ami_status", want.ami_status, got.ami_status);
         compare_field("heartbeat_mission", want.heartbeat_mission, got.heartbeat_mission);
         compare_field("torque_request", int'(want.torque_request),
                       int'(got.torque_request));
         compare_field("launch_pulse", want.launch_pulse, got.launch_pulse);
         compare_field("launch_mission_code", want.launch_mission_code,
                       got.launch_mission_code);
      endfunction

   endclass

endpackage

[tb/sv/autonomous_drive_supervisor_fsm_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Autonomous drive supervisor testbench
// Walks the supervisor through every reachable state with a directed mission sequence,
// then feeds state-aware random ticks under three idling mixes on both
// channels, checking every result transaction against a tracked copy of the
// state machine.
// ----------------------------------------------------------------------------
module autonomous_drive_supervisor_fsm_unit_tb;

   import adsf_pkg::*;
   import adsf_supervisor_checker_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic clock = 1'b0;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   int   cycles = 0;

   adsf_req_if req ();
   adsf_rsp_if rsp ();

   supervisor_checker sb = new();

   autonomous_drive_supervisor_fsm_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp)
   );

   always begin
      #4 clock <= 1'b1;
      #4 clock <= 1'b0;
   end

   always @(posedge clock) begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.supervisor_state    = rsp.supervisor_state;
         got.as_status           = rsp.as_status;
         got.ami_status          = rsp.ami_status;
         got.heartbeat_mission   = rsp.heartbeat_mission;
         got.torque_request      = rsp.torque_request;
         got.launch_pulse        = rsp.launch_pulse;
         got.launch_mission_code = rsp.launch_mission_code;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("autonomous_drive_supervisor_fsm_unit regression: fail");
         $finish;
      end
   end

   function automatic tick_type make_tick(int sw, int go, int es, logic [2:0] bc,
                                          logic [1:0] ss, logic [2:0] sm,
                                          logic signed [15:0] tq);
      tick_type t;
      t.res_switch_forward = sw[0];
      t.res_go_button      = go[0];
      t.res_estop          = es[0];
      t.brake_ctrl_state   = bc;
      t.steer_state        = ss;
      t.steer_mission      = sm;
      t.torque_demand      = tq;
      return t;
   endfunction

   // Mostly pushes the machine toward its next state; the rest is noise.
   function automatic tick_type next_tick(logic [3:0] st);
      tick_type t;
      t.res_switch_forward = 1'($urandom_range(1));
      t.res_go_button      = 1'($urandom_range(1));
      t.res_estop          = ($urandom_range(99) < 4);
      t.brake_ctrl_state   = 3'($urandom_range(7));
      t.steer_state        = 2'($urandom_range(3));
      t.steer_mission      = 3'($urandom_range(7));
      case ($urandom_range(9))
         0:       t.torque_demand = 16'sh7FFF;
         1:       t.torque_demand = 16'sh8000;
         default: t.torque_demand = 16'($urandom);
      endcase
      if ($urandom_range(99) < 75) begin
         case (st)
            ST_START: begin
               t.res_switch_forward = 1'b0;
               t.steer_state        = $urandom_range(1) ? SS_ACK : SS_SELECT;
            end
            ST_SELECT, ST_WAIT: begin
               t.steer_state   = ($urandom_range(3) != 0) ? SS_ACK : SS_SELECT;
               t.steer_mission = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
                                                          : 3'($urandom_range(4));
            end
            ST_CHECK: begin
               t.res_switch_forward = 1'b1;
               t.brake_ctrl_state   = BC_READY;
            end
            ST_READY: t.brake_ctrl_state = $urandom_range(1) ? BC_READY : BC_DRIVE;
            ST_RELEASE, ST_DRIVE: t.brake_ctrl_state = BC_DRIVE;
            ST_EMERG: begin
               t.res_switch_forward = 1'b0;
               t.res_estop          = 1'b0;
            end
            default: ;
         endcase
      end
      return t;
   endfunction

   task automatic send_tick(input tick_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid              <= 1'b1;
      req.res_switch_forward <= t.res_switch_forward;
      req.res_go_button      <= t.res_go_button;
      req.res_estop          <= t.res_estop;
      req.brake_ctrl_state   <= t.brake_ctrl_state;
      req.steer_state        <= t.steer_state;
      req.steer_mission      <= t.steer_mission;
      req.torque_demand      <= t.torque_demand;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_tick(t);
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic send_random(input int count);
      repeat (count) send_tick(next_tick(sb.state_now()));
   endtask

   initial begin
      send_idle_pct = 37;
      recv_idle_pct = 76;
      reset                  <= 1'b1;
      req.valid              <= 1'b0;
      req.res_switch_forward <= 1'b0;
      req.res_go_button      <= 1'b0;
      req.res_estop          <= 1'b0;
      req.brake_ctrl_state   <= BC_OTHER;
      req.steer_state        <= SS_OTHER;
      req.steer_mission      <= MS_NONE;
      req.torque_demand      <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed mission walk: every reachable state, every mission, the e-stop override,
      // acknowledge without a mission, and unused codes.
      send_tick(make_tick(1, 0, 0, BC_OTHER, SS_OTHER, MS_NONE, 16'sh7FFF));
      send_tick(make_tick(0, 0, 0, BC_OTHER, SS_SELECT, MS_NONE, 16'sh0000));
      send_tick(make_tick(0, 0, 0, BC_OTHER, SS_ACK, MS_NONE, 16'sh0001));
      send_tick(make_tick(1, 1, 0, BC_READY, SS_ACK, MS_INSPECT, 16'sh8000));
      send_tick(make_tick(1, 0, 0, BC_DRIVE, SS_OTHER, MS_NONE, 16'sh7FFF));
      send_tick(make_tick(1, 1, 0, BC_DRIVE, SS_OTHER, MS_NONE, 16'sh8000));
      send_tick(make_tick(1, 0, 0, BC_SHUTDOWN, SS_OTHER, MS_NONE, 16'sh1234));
      send_tick(make_tick(1, 0, 0, BC_OTHER, SS_OTHER, MS_NONE, 16'sh0000));
      send_tick(make_tick(0, 0, 0, BC_OTHER, SS_OTHER, MS_NONE, 16'sh0000));
      send_tick(make_tick(0, 0, 0, BC_READY, SS_ACK, 3'd7, 16'sh00FF));
      send_tick(make_tick(1, 0, 0, BC_READY, SS_OTHER, MS_NONE, 16'sh0000));
      send_tick(make_tick(1, 0, 0, BC_SHUTDOWN, SS_OTHER, MS_NONE, 16'sh0000));
      send_tick(make_tick(0, 0, 1, BC_OTHER, SS_OTHER, MS_NONE, 16'sh7FFF));
      send_tick(make_tick(0, 0, 0, BC_OTHER, SS_OTHER, MS_NONE, 16'sh0000));
      send_tick(make_tick(0, 0, 0, BC_OTHER, SS_ACK, MS_MANUAL, 16'sh0000));
      send_tick(make_tick(1, 1, 0, BC_READY, SS_OTHER, MS_NONE, 16'sh0000));
      send_tick(make_tick(1, 0, 0, BC_SHUTDOWN, SS_OTHER, MS_NONE, 16'sh5555));
      send_tick(make_tick(0, 0, 0, BC_OTHER, SS_OTHER, MS_NONE, 16'sh0000));
      send_tick(make_tick(0, 0, 0, BC_OTHER, SS_ACK, MS_BRAKE, 16'sh0000));
      send_tick(make_tick(1, 1, 1, BC_READY, SS_OTHER, MS_NONE, 16'shAAAA));
      send_tick(make_tick(0, 0, 0, BC_BRAKE, SS_OTHER, MS_NONE, 16'sh0000));
      send_tick(make_tick(0, 0, 0, BC_OTHER, SS_ACK, MS_TRACK, 16'sh0000));
      // Brake and steering codes outside the defined set must not move the machine.
      send_tick(make_tick(1, 1, 0, 3'd7, 2'd3, 3'd5, 16'shFFFF));
      send_tick(make_tick(1, 1, 0, BC_READY, SS_OTHER, 3'd6, 16'sh0000));
      send_tick(make_tick(1, 0, 0, BC_DRIVE, SS_SELECT, MS_NONE, 16'sh1234));
      send_tick(make_tick(1, 0, 1, BC_DRIVE, SS_OTHER, MS_NONE, 16'sh7FFF));

      send_random(400);
      drain_results();

      send_idle_pct = 76;
      recv_idle_pct = 37;
      send_random(400);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(300);

      drain_results();
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("autonomous_drive_supervisor_fsm_unit regression: pass");
      end else begin
         $display("autonomous_drive_supervisor_fsm_unit regression: fail");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/adsf_pkg.sv
sv/adsf_channels.sv
sv/adsf_step.sv
sv/autonomous_drive_supervisor_fsm_unit.sv
tb/sv/adsf_supervisor_checker_pkg.sv
tb/sv/autonomous_drive_supervisor_fsm_unit_tb.sv
